/* hdl/uvs_pkg.sv */
// Package: shared types, grid constants and trigonometry tables for the UV sphere generator.
`timescale 1ns / 1ps

package uvs_pkg;

  // Grid resolution
  localparam int SEGMENTS_AROUND = 64;
  localparam int SEGMENTS_DOWN   = 64;

  // Field widths fixed by the interface
  localparam int STEP_W  = 7;
  localparam int POS_W   = 32;
  localparam int NORM_W  = 16;
  localparam int TEX_W   = 17;
  localparam int IDX_W   = 13;
  localparam int RAD_W   = 31;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Clamped step widths follow the segment counts
  localparam int COL_W = $clog2(SEGMENTS_AROUND + 1);
  localparam int ROW_W = $clog2(SEGMENTS_DOWN + 1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [NORM_W-1:0] q15_t;
  typedef logic [TEX_W-1:0]         tex_t;

  typedef q15_t az_trig_t  [SEGMENTS_AROUND+1];
  typedef q15_t pol_trig_t [SEGMENTS_DOWN+1];
  typedef tex_t az_tex_t   [SEGMENTS_AROUND+1];
  typedef tex_t pol_tex_t  [SEGMENTS_DOWN+1];

  typedef struct packed {
    logic [STEP_W-1:0] column_step;
    logic [STEP_W-1:0] row_step;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
    logic [IDX_W-1:0]         vertex_index;
  } vertex_t;

  // Quarter-wave sine in Q1.15 by a Taylor series in Q2.30 (elaboration only)
  function automatic q15_t qsin(input int unsigned k_in);
    int unsigned k;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    k = (k_in > 1024) ? 1024 : k_in;
    x = (HALF_PI_Q30 * 64'(k) + 64'd512) >> 10;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) sum = 32767;
    return q15_t'(sum);
  endfunction

  // Full-turn sine over a 4096-step phase
  function automatic q15_t wave_sin(input int unsigned p_in);
    int unsigned p;
    int unsigned q;
    int unsigned r;
    q15_t        m;
    p = p_in & 4095;
    q = p >> 10;
    r = p & 1023;
    m = q[0] ? qsin(1024 - r) : qsin(r);
    return (q >= 2) ? -m : m;
  endfunction

  function automatic int unsigned az_phase(input int unsigned col);
    return ((col * 4096 + SEGMENTS_AROUND / 2) / SEGMENTS_AROUND) & 4095;
  endfunction

  function automatic int unsigned pol_phase(input int unsigned row);
    return (row * 2048 + SEGMENTS_DOWN / 2) / SEGMENTS_DOWN;
  endfunction

  function automatic az_trig_t build_az(input logic cosine);
    az_trig_t tab;
    for (int i = 0; i <= SEGMENTS_AROUND; i++) begin
      tab[i] = wave_sin(az_phase(i) + (cosine ? 1024 : 0));
    end
    return tab;
  endfunction

  function automatic pol_trig_t build_pol(input logic cosine);
    pol_trig_t tab;
    for (int i = 0; i <= SEGMENTS_DOWN; i++) begin
      tab[i] = wave_sin(pol_phase(i) + (cosine ? 1024 : 0));
    end
    return tab;
  endfunction

  function automatic az_tex_t build_tex_u();
    az_tex_t tab;
    for (int i = 0; i <= SEGMENTS_AROUND; i++) begin
      tab[i] = tex_t'((i * 65536 + SEGMENTS_AROUND / 2) / SEGMENTS_AROUND);
    end
    return tab;
  endfunction

  function automatic pol_tex_t build_tex_v();
    pol_tex_t tab;
    for (int i = 0; i <= SEGMENTS_DOWN; i++) begin
      tab[i] = tex_t'((i * 65536 + SEGMENTS_DOWN / 2) / SEGMENTS_DOWN);
    end
    return tab;
  endfunction

  // Per-step lookup tables
  localparam az_trig_t  AZ_SIN  = build_az(1'b0);
  localparam az_trig_t  AZ_COS  = build_az(1'b1);
  localparam pol_trig_t POL_SIN = build_pol(1'b0);
  localparam pol_trig_t POL_COS = build_pol(1'b1);
  localparam az_tex_t   TEX_U   = build_tex_u();
  localparam pol_tex_t  TEX_V   = build_tex_v();

endpackage

/* hdl/uv_sphere_vertex_generator.sv */
// UV sphere vertex generator: five-stage pipeline from grid step to vertex.
// A transfer is registered in stages 1 to 4 in turn and then in the output register (stage 5).
// Throughput: one vertex per cycle while vertex_stall is low; the stages advance
// independently, so a bubble is filled while the output is stalled (ready ripples back per stage).
// Stage depth is set by the two 16x16 normal multiplies and the 16x31 radius
// multiplies, each in a stage of its own.
// Reset (synchronous, rst high): all stage valids clear, center is 0, radius 1.0.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // grid point channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  // vertex channel
  output logic                 vertex_valid,
  input  logic                 vertex_stall,
  output vertex_t              vertex,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [IDX_W-1:0] vertex_index;
  } tag_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } st1_t;

  typedef struct packed {
    q15_t saz;
    q15_t caz;
    q15_t spol;
    q15_t cpol;
    tag_t tag;
  } st2_t;

  typedef struct packed {
    q15_t nx;
    q15_t ny;
    q15_t nz;
    tag_t tag;
  } st3_t;

  typedef struct packed {
    logic signed [47:0] px;
    logic signed [47:0] py;
    logic signed [47:0] pz;
    q15_t               nx;
    q15_t               ny;
    q15_t               nz;
    tag_t               tag;
  } st4_t;

  localparam logic [COL_W-1:0] COL_MAX   = COL_W'(SEGMENTS_AROUND);
  localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(SEGMENTS_DOWN);
  localparam logic [IDX_W-1:0] ROW_PITCH = IDX_W'(SEGMENTS_AROUND + 1);

  logic signed [POS_W-1:0] center_x;
  logic signed [POS_W-1:0] center_y;
  logic signed [POS_W-1:0] center_z;
  logic [RAD_W-1:0]        radius;

  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;
  st1_t s1, s1_next;
  st2_t s2, s2_next;
  st3_t s3, s3_next;
  st4_t s4, s4_next;
  vertex_t s5_next;

  // Round a Q1.15 product half up back to Q1.15
  function automatic q15_t mul_q15(input q15_t a, input q15_t b);
    logic signed [31:0] p;
    p = 32'(a) * 32'(b) + 32'sd16384;
    return q15_t'(p >>> 15);
  endfunction

  // Round the radius product to Q16.16, add the center, saturate
  function automatic logic signed [POS_W-1:0] place(input logic signed [47:0] p,
                                                    input logic signed [POS_W-1:0] c);
    logic signed [32:0] r;
    logic signed [33:0] s;
    r = 33'((p + 48'sd16384) >>> 15);
    s = 34'(r) + 34'(c);
    if (s > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[POS_W-1:0];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= RADIUS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_CENTER_Z: center_z <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data[RAD_W-1:0];
        default:      ;
      endcase
    end
  end

  // Each stage loads when empty or when the stage after it moves
  assign adv5 = !v5 || !vertex_stall;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign item_stall = !adv1;

  // Stage 1: clamp steps
  always_comb begin
    s1_next.col = ({25'd0, item.column_step} > SEGMENTS_AROUND) ? COL_MAX
                                                                : COL_W'(item.column_step);
    s1_next.row = ({25'd0, item.row_step} > SEGMENTS_DOWN) ? ROW_MAX
                                                           : ROW_W'(item.row_step);
  end

  // Stage 2: table lookups and linear index
  always_comb begin
    s2_next.saz  = AZ_SIN[s1.col];
    s2_next.caz  = AZ_COS[s1.col];
    s2_next.spol = POL_SIN[s1.row];
    s2_next.cpol = POL_COS[s1.row];
    s2_next.tag.tex_u = TEX_U[s1.col];
    s2_next.tag.tex_v = TEX_V[s1.row];
    s2_next.tag.vertex_index = IDX_W'(s1.row) * ROW_PITCH + IDX_W'(s1.col);
  end

  // Stage 3: unit normal
  always_comb begin
    s3_next.nx  = mul_q15(s2.caz, s2.spol);
    s3_next.ny  = s2.cpol;
    s3_next.nz  = mul_q15(s2.saz, s2.spol);
    s3_next.tag = s2.tag;
  end

  // Stage 4: scale by radius
  always_comb begin
    s4_next.px  = 48'(s3.nx) * $signed({17'd0, radius});
    s4_next.py  = 48'(s3.ny) * $signed({17'd0, radius});
    s4_next.pz  = 48'(s3.nz) * $signed({17'd0, radius});
    s4_next.nx  = s3.nx;
    s4_next.ny  = s3.ny;
    s4_next.nz  = s3.nz;
    s4_next.tag = s3.tag;
  end

  // Stage 5: round, offset, saturate into the output register
  always_comb begin
    s5_next.pos_x        = place(s4.px, center_x);
    s5_next.pos_y        = place(s4.py, center_y);
    s5_next.pos_z        = place(s4.pz, center_z);
    s5_next.normal_x     = s4.nx;
    s5_next.normal_y     = s4.ny;
    s5_next.normal_z     = s4.nz;
    s5_next.tex_u        = s4.tag.tex_u;
    s5_next.tex_v        = s4.tag.tex_v;
    s5_next.vertex_index = s4.tag.vertex_index;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) v1 <= item_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
    end
  end

  // Stage payloads; hold while stalled
  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
    if (adv4) s4 <= s4_next;
    if (adv5) vertex <= s5_next;
  end

  assign vertex_valid = v5;

endmodule
